// ===== rtl/core/cfa_pkg.sv =====
package cfa_pkg;

    localparam int POOL_FRAMES_DEF = 256;

    typedef enum logic [1:0] {
        FIT_NEXT  = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_RSVD  = 2'd3
    } t_fit;

    typedef enum logic [1:0] {
        ST_PLACED    = 2'd0,
        ST_COMPACTED = 2'd1,
        ST_SKIPPED   = 2'd2,
        ST_REMOVED   = 2'd3
    } t_status;

    localparam logic CFG_FIT_POLICY = 1'b0;
    localparam logic CFG_MOVE_TIME  = 1'b1;
    localparam logic FUNC_PLACE     = 1'b0;
    localparam logic FUNC_REMOVE    = 1'b1;

    typedef struct packed {
        logic       func;
        logic [4:0] owner;
        logic [8:0] frame_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  base_frame;
        logic [8:0]  frames_moved;
        logic [15:0] move_delay;
    } t_rsp;

    // Datapath sweep kinds
    typedef enum logic [2:0] {
        SW_CLEAR   = 3'd0,
        SW_REMOVE  = 3'd1,
        SW_SCAN    = 3'd2,
        SW_COMPACT = 3'd3,
        SW_FILL    = 3'd4
    } t_sweep;

    // Controller to datapath
    typedef struct packed {
        logic   start;
        t_sweep kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic found;
        logic enough;
    } t_sts;

endpackage

// ===== rtl/core/contiguous_frame_allocator.sv =====
// Contiguous frame allocator. Handles one request at a time and stalls its
// input while busy. After reset the owner RAM is cleared by one pass during
// which the input stalls. A place request runs a scan pass (free count, best
// and worst holes and next-fit runs together), then a fill pass over the
// frames needed; when only compaction can make room, a compaction pass comes
// in between and the fill pass covers the rest of the pool. A remove runs one
// pass; a place request with owner zero or no frames is skipped without a
// pass. Every pass is a sweep of the single RAM, one frame per cycle.
module contiguous_frame_allocator #(
    parameter int POOL_FRAMES = cfa_pkg::POOL_FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cfa_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output cfa_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_data
);
    import cfa_pkg::*;

    logic [1:0] r_fit;
    logic [7:0] r_move_time;
    t_cmd cmd;
    t_sts sts;
    t_req req;
    t_rsp rsp;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit       <= FIT_NEXT;
            r_move_time <= 8'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FIT_POLICY) r_fit <= i_cfg_data[1:0];
            else r_move_time <= i_cfg_data;
        end
    end

    cfa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_req  (req),
        .o_cmd  (cmd),
        .i_sts  (sts),
        .i_rsp  (rsp),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_rsp)
    );

    cfa_datapath #(.POOL_FRAMES(POOL_FRAMES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req      (req),
        .i_fit      (r_fit),
        .i_move_time(r_move_time),
        .o_rsp      (rsp)
    );
endmodule

// ===== rtl/core/cfa_ram.sv =====
module cfa_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/cfa_datapath.sv =====
module cfa_datapath #(
    parameter int POOL_FRAMES = cfa_pkg::POOL_FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfa_pkg::t_cmd i_cmd,
    output cfa_pkg::t_sts o_sts,
    input  cfa_pkg::t_req i_req,
    input  logic [1:0]    i_fit,
    input  logic [7:0]    i_move_time,
    output cfa_pkg::t_rsp o_rsp
);
    import cfa_pkg::*;

    localparam int AW = $clog2(POOL_FRAMES);
    localparam int CW = AW + 1;
    localparam int XW = ((CW > 9) ? CW : 9) + 1;
    localparam int PW = XW + 8;
    localparam logic [XW-1:0] LAST = XW'(POOL_FRAMES - 1);
    localparam logic [XW-1:0] POOL = XW'(POOL_FRAMES);

    // Sweep engine: address issue, then read data in the next cycle
    t_sweep        r_kind;
    logic          r_busy;
    logic [XW-1:0] r_addr, r_end;
    logic          r_dv;
    logic [XW-1:0] r_daddr;
    logic [4:0]    rdata;
    logic          issue;
    logic          sweep_done;
    logic [XW-1:0] sw_lo, sw_hi;

    // Scan results
    logic [XW-1:0] r_free;
    logic [XW-1:0] r_run, r_run_at;
    logic          r_fit_found;
    logic [XW-1:0] r_best_len, r_best_at;
    logic [XW-1:0] r_nrun;
    logic          r_hi_found, r_lo_found;
    logic [XW-1:0] r_hi_at, r_lo_at;
    logic [XW-1:0] r_rove;

    // Compaction and fill
    logic          r_comp;
    logic [XW-1:0] r_dst, r_moved;
    logic [XW-1:0] r_fill_at, r_fill_end;

    logic [XW-1:0] need;
    logic          use_fit;
    logic          sel_found;
    logic [XW-1:0] sel_at;
    logic [XW-1:0] place_end;
    logic          data_free;
    logic [XW-1:0] run_len, run_at;
    logic          hole_close, hole_take;
    logic [XW-1:0] nrun_base, nrun_len;

    logic          we;
    logic [AW-1:0] waddr;
    logic [4:0]    wdata;

    assign need      = XW'(i_req.frame_count);
    assign use_fit   = (i_fit == FIT_BEST) || (i_fit == FIT_WORST);
    assign sel_found = use_fit ? r_fit_found : (r_hi_found || r_lo_found);
    assign sel_at    = use_fit ? r_best_at : (r_hi_found ? r_hi_at : r_lo_at);
    assign place_end = sel_at + need;
    assign data_free = (rdata == 5'd0);

    assign issue      = r_busy && (r_addr < r_end);
    assign sweep_done = r_busy && !issue && !r_dv;

    // Hole tracking for best and worst fit, no break at the rover
    assign run_len    = data_free ? r_run + XW'(1) : r_run;
    assign run_at     = (r_run == '0) ? r_daddr : r_run_at;
    assign hole_close = r_dv && ((!data_free && r_run != '0) || (data_free && r_daddr == LAST));
    assign hole_take  = hole_close && (run_len >= need) &&
                        (!r_fit_found ||
                         (i_fit == FIT_BEST  && run_len < r_best_len) ||
                         (i_fit == FIT_WORST && run_len > r_best_len));

    // Next-fit runs restart at the rover so none joins across the wrap
    assign nrun_base = (r_daddr == r_rove) ? '0 : r_nrun;
    assign nrun_len  = data_free ? nrun_base + XW'(1) : '0;

    cfa_ram #(.WIDTH(5), .DEPTH(POOL_FRAMES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(rdata)
    );

    // Pick sweep range
    always_comb begin
        sw_lo = '0;
        sw_hi = POOL;
        if (i_cmd.kind == SW_FILL) begin
            if (r_comp) begin
                sw_lo = r_dst;
            end else begin
                sw_lo = sel_at;
                sw_hi = place_end;
            end
        end
    end

    // Write control per sweep kind
    always_comb begin
        we    = 1'b0;
        waddr = r_daddr[AW-1:0];
        wdata = 5'd0;
        if (r_dv) begin
            case (r_kind)
                SW_CLEAR: we = 1'b1;
                SW_REMOVE: begin
                    we = (rdata == i_req.owner) && (i_req.owner != 5'd0);
                end
                SW_COMPACT: begin
                    if (!data_free && r_dst != r_daddr) begin
                        we    = 1'b1;
                        waddr = r_dst[AW-1:0];
                        wdata = rdata;
                    end
                end
                SW_FILL: begin
                    // owner over the block, free frames after it
                    we    = 1'b1;
                    wdata = (r_daddr < r_fill_end) ? i_req.owner : 5'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= SW_CLEAR;
            r_busy      <= 1'b0;
            r_addr      <= '0;
            r_end       <= '0;
            r_dv        <= 1'b0;
            r_daddr     <= '0;
            r_free      <= '0;
            r_run       <= '0;
            r_run_at    <= '0;
            r_fit_found <= 1'b0;
            r_best_len  <= '0;
            r_best_at   <= '0;
            r_nrun      <= '0;
            r_hi_found  <= 1'b0;
            r_lo_found  <= 1'b0;
            r_hi_at     <= '0;
            r_lo_at     <= '0;
            r_rove      <= '0;
            r_comp      <= 1'b0;
            r_dst       <= '0;
            r_moved     <= '0;
            r_fill_at   <= '0;
            r_fill_end  <= '0;
        end else begin
            // Advance the sweep
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_kind <= i_cmd.kind;
                r_addr <= sw_lo;
                r_end  <= sw_hi;
            end else begin
                if (sweep_done) r_busy <= 1'b0;
                if (issue) r_addr <= r_addr + XW'(1);
            end
            r_dv    <= issue;
            r_daddr <= r_addr;

            // Count free frames and find holes in one pass
            if (i_cmd.start && i_cmd.kind == SW_SCAN) begin
                r_free      <= '0;
                r_run       <= '0;
                r_run_at    <= '0;
                r_fit_found <= 1'b0;
                r_best_len  <= '0;
                r_best_at   <= '0;
                r_nrun      <= '0;
                r_hi_found  <= 1'b0;
                r_lo_found  <= 1'b0;
                r_hi_at     <= '0;
                r_lo_at     <= '0;
            end else if (r_dv && r_kind == SW_SCAN) begin
                if (data_free) r_free <= r_free + XW'(1);
                r_run <= data_free ? run_len : '0;
                if (data_free && r_run == '0) r_run_at <= r_daddr;
                if (hole_take) begin
                    r_fit_found <= 1'b1;
                    r_best_len  <= run_len;
                    r_best_at   <= run_at;
                end
                r_nrun <= nrun_len;
                if (data_free && nrun_len == need) begin
                    if (r_daddr >= r_rove) begin
                        if (!r_hi_found) begin
                            r_hi_found <= 1'b1;
                            r_hi_at    <= r_daddr + XW'(1) - need;
                        end
                    end else if (!r_lo_found) begin
                        r_lo_found <= 1'b1;
                        r_lo_at    <= r_daddr + XW'(1) - need;
                    end
                end
            end

            // Mark a compacted request
            if (i_cmd.start) begin
                if (i_cmd.kind == SW_SCAN) r_comp <= 1'b0;
                else if (i_cmd.kind == SW_COMPACT) r_comp <= 1'b1;
            end

            // Slide occupied frames down, counting each frame that moves
            if (i_cmd.start && i_cmd.kind == SW_COMPACT) begin
                r_dst   <= '0;
                r_moved <= '0;
            end else if (r_dv && r_kind == SW_COMPACT && !data_free) begin
                r_dst <= r_dst + XW'(1);
                if (r_dst != r_daddr) r_moved <= r_moved + XW'(1);
            end

            // Latch the block and move the rover after a direct next-fit placement
            if (i_cmd.start && i_cmd.kind == SW_FILL) begin
                r_fill_at  <= sw_lo;
                r_fill_end <= sw_lo + need;
                if (!r_comp && !use_fit) r_rove <= (place_end >= POOL) ? '0 : place_end;
            end
        end
    end

    assign o_sts.done   = sweep_done;
    assign o_sts.found  = sel_found;
    assign o_sts.enough = (r_free >= need);

    // Result fields
    logic [PW-1:0] prod;
    assign prod = PW'(r_moved) * PW'(i_move_time);
    always_comb begin
        o_rsp              = '0;
        o_rsp.status       = r_comp ? ST_COMPACTED : ST_PLACED;
        o_rsp.base_frame   = r_fill_at[7:0];
        o_rsp.frames_moved = (r_moved > XW'(511)) ? 9'h1FF : r_moved[8:0];
        o_rsp.move_delay   = (prod > PW'(16'hFFFF)) ? 16'hFFFF : prod[15:0];
    end
endmodule

// ===== rtl/core/cfa_ctrl.sv =====
module cfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cfa_pkg::t_req i_req,
    output cfa_pkg::t_req o_req,
    output cfa_pkg::t_cmd o_cmd,
    input  cfa_pkg::t_sts i_sts,
    input  cfa_pkg::t_rsp i_rsp,
    output logic          o_valid,
    input  logic          i_stall,
    output cfa_pkg::t_rsp o_rsp
);
    import cfa_pkg::*;

    typedef enum logic [6:0] {
        S_INIT    = 7'b000_0001,
        S_IDLE    = 7'b000_0010,
        S_REMOVE  = 7'b000_0100,
        S_SCAN    = 7'b000_1000,
        S_COMPACT = 7'b001_0000,
        S_FILL    = 7'b010_0000,
        S_OUT     = 7'b100_0000
    } t_state;

    t_state  r_state, n_state;
    t_req    r_req;
    t_rsp    r_out, out_w;
    logic    r_ovalid;
    logic    r_first;
    logic    take;
    logic    enter;
    t_status r_st;

    assign o_req   = r_req;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_out;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign take    = i_valid && !o_stall;

    // Issue sweep start in the first cycle of each sweep state
    always_comb begin
        o_cmd.start = r_first;
        case (r_state)
            S_INIT:    o_cmd.kind = SW_CLEAR;
            S_REMOVE:  o_cmd.kind = SW_REMOVE;
            S_COMPACT: o_cmd.kind = SW_COMPACT;
            S_FILL:    o_cmd.kind = SW_FILL;
            default:   o_cmd.kind = SW_SCAN;
        endcase
    end

    // Advance through sweeps
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: if (i_sts.done) n_state = S_IDLE;
            S_IDLE: begin
                if (take) begin
                    if (i_req.func == FUNC_REMOVE) n_state = S_REMOVE;
                    else if (i_req.owner == 5'd0 || i_req.frame_count == 9'd0)
                        n_state = S_OUT;
                    else n_state = S_SCAN;
                end
            end
            S_REMOVE: if (i_sts.done) n_state = S_OUT;
            S_SCAN: begin
                if (i_sts.done) begin
                    if (i_sts.found) n_state = S_FILL;
                    else if (i_sts.enough) n_state = S_COMPACT;
                    else n_state = S_OUT;
                end
            end
            S_COMPACT: if (i_sts.done) n_state = S_FILL;
            S_FILL: if (i_sts.done) n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign enter = (n_state != r_state) &&
                   (n_state inside {S_REMOVE, S_SCAN, S_COMPACT, S_FILL});

    // Build the response transaction
    always_comb begin
        out_w        = '0;
        out_w.status = r_st;
        if (r_st inside {ST_PLACED, ST_COMPACTED}) out_w.base_frame = i_rsp.base_frame;
        if (r_st == ST_COMPACTED) begin
            out_w.frames_moved = i_rsp.frames_moved;
            out_w.move_delay   = i_rsp.move_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_first  <= 1'b1;
            r_ovalid <= 1'b0;
            r_st     <= ST_SKIPPED;
            r_req    <= '0;
            r_out    <= '0;
        end else begin
            r_state <= n_state;
            r_first <= enter;
            if (take) r_req <= i_req;

            // Track the outcome of the request
            if (take)
                r_st <= (i_req.func == FUNC_REMOVE) ? ST_REMOVED : ST_SKIPPED;
            else if (r_state == S_SCAN && i_sts.done && i_sts.found)
                r_st <= ST_PLACED;
            else if (r_state == S_COMPACT && i_sts.done)
                r_st <= ST_COMPACTED;

            // Load the output register, drop it once taken
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
                r_out    <= out_w;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule
